/* design/rsi_pkg.sv */
// Shared types, constants and helpers for the relative strength index block.
`default_nettype none

package rsi_pkg;

  localparam int MAX_PERIOD_DEF  = 64;
  localparam int PRICE_WIDTH_DEF = 32;
  localparam int PERIOD_W        = 7;
  localparam int PERIOD_RESET    = 14;
  localparam int RSI_W           = 14;

  localparam logic [RSI_W-1:0] RSI_FULL_SCALE = 14'd10000;

  // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
  localparam int SCALE_TERMS = 5;
  localparam int SCALE_IDX_W = $clog2(SCALE_TERMS);

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  function automatic int scale_shift(input logic [SCALE_IDX_W-1:0] idx);
    int sh;
    case (idx)
      SCALE_IDX_W'(0): sh = 4;
      SCALE_IDX_W'(1): sh = 8;
      SCALE_IDX_W'(2): sh = 9;
      SCALE_IDX_W'(3): sh = 10;
      SCALE_IDX_W'(4): sh = 13;
      default:         sh = 0;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

/* design/rsi_alu.sv */
// Shared add/subtract unit with carry out (carry set on subtract means a >= b).
`default_nettype none

module rsi_alu import rsi_pkg::*; #(
  parameter int W = 52
) (
  input  alu_op_e        op_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [W-1:0]   res_o,
  output logic           carry_o
);

  logic [W-1:0] b_eff;
  logic [W:0]   sum;

  assign b_eff   = (op_i == ALU_SUB) ? ~b_i : b_i;
  assign sum     = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, (op_i == ALU_SUB)};
  assign res_o   = sum[W-1:0];
  assign carry_o = sum[W];

endmodule

`default_nettype wire

/* design/relative_strength_index.sv */
// Relative strength index over a price stream, simple-average form.
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+-------------------------
//  input     | in_valid_i / in_stall_o         | price_i, series_start_i
//  result    | out_valid_o / out_stall_i       | rsi_value_o
//  config    | rsi_period_we_i                 | rsi_period_i
//
// One shared adder does every step: price delta, window retire/insert,
// gain+loss sum, the x10000 scaling as five shift-add terms and a 14-step
// restoring divide. Input stalls from delta through output; zero loss
// skips scaling and divide, a filling window stops after its update and
// a series start does not stall. A result waits in the output register,
// so a stalled output holds back input only if the next result is ready.
// Reset is asynchronous; period resets to 14 and the history is empty.
`default_nettype none

module relative_strength_index import rsi_pkg::*; #(
  parameter int MAX_PERIOD  = MAX_PERIOD_DEF,
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [PRICE_WIDTH-1:0] price_i,
  input  logic                   series_start_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [RSI_W-1:0]       rsi_value_o,
  input  logic                   rsi_period_we_i,
  input  logic [PERIOD_W-1:0]    rsi_period_i
);

  localparam int PTR_W = $clog2(MAX_PERIOD);
  localparam int CNT_W = $clog2(MAX_PERIOD + 1);
  localparam int TOT_W = PRICE_WIDTH + $clog2(MAX_PERIOD);
  localparam int NUM_W = TOT_W + RSI_W;
  localparam int BIT_W = $clog2(RSI_W);
  localparam int ENT_W = PRICE_WIDTH + 1;

  localparam logic [CNT_W-1:0] ResetPeriod =
    (PERIOD_RESET > MAX_PERIOD) ? CNT_W'(MAX_PERIOD) : CNT_W'(PERIOD_RESET);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_DELTA  = 10'b00_0000_0010,
    ST_NEG    = 10'b00_0000_0100,
    ST_RETIRE = 10'b00_0000_1000,
    ST_INSERT = 10'b00_0001_0000,
    ST_SUM    = 10'b00_0010_0000,
    ST_SCALE  = 10'b00_0100_0000,
    ST_DINIT  = 10'b00_1000_0000,
    ST_DIV    = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       period_q, period_d;
  logic                   have_prev_q, have_prev_d;
  logic [PRICE_WIDTH-1:0] prev_q, prev_d;
  logic [TOT_W-1:0]       gain_q, gain_d;
  logic [TOT_W-1:0]       loss_q, loss_d;
  logic [CNT_W-1:0]       seen_q, seen_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic                   out_valid_q, out_valid_d;
  logic [RSI_W-1:0]       rsi_q, rsi_d;

  logic [PRICE_WIDTH-1:0] price_q, price_d;
  logic [PRICE_WIDTH-1:0] mag_q, mag_d;
  logic                   up_q, up_d;
  logic [TOT_W-1:0]       sum_q, sum_d;
  logic [NUM_W-1:0]       num_q, num_d;
  logic [TOT_W-1:0]       rem_q, rem_d;
  logic [RSI_W-1:0]       quo_q, quo_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [SCALE_IDX_W-1:0] mul_cnt_q, mul_cnt_d;

  logic [ENT_W-1:0]       ring_mem [MAX_PERIOD];
  logic [ENT_W-1:0]       mem_rd_q;
  logic                   mem_we;
  logic                   mem_re;

  alu_op_e                alu_op;
  logic [NUM_W-1:0]       alu_a, alu_b, alu_res;
  logic                   alu_carry;

  logic                   in_accept;
  logic [CNT_W-1:0]       eff_period;
  logic [CNT_W-1:0]       ptr_inc;
  logic [PTR_W-1:0]       ptr_nxt;
  logic [TOT_W:0]         trial;
  logic [RSI_W-1:0]       num_lo;
  logic                   old_up;
  logic [PRICE_WIDTH-1:0] old_mag;

  rsi_alu #(.W(NUM_W)) u_rsi_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign rsi_value_o = rsi_q;

  assign old_up  = mem_rd_q[PRICE_WIDTH];
  assign old_mag = mem_rd_q[PRICE_WIDTH-1:0];
  assign num_lo  = num_q[RSI_W-1:0];
  assign trial   = {rem_q, num_lo[bit_q]};
  assign ptr_inc = CNT_W'(ptr_q) + CNT_W'(1);
  assign ptr_nxt = (ptr_inc >= period_q) ? '0 : ptr_inc[PTR_W-1:0];
  assign mem_re  = in_accept;

  always_comb begin
    if (rsi_period_i == '0) begin
      eff_period = CNT_W'(1);
    end else if (int'(rsi_period_i) > MAX_PERIOD) begin
      eff_period = CNT_W'(MAX_PERIOD);
    end else begin
      eff_period = CNT_W'(rsi_period_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    period_d    = period_q;
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    gain_d      = gain_q;
    loss_d      = loss_q;
    seen_d      = seen_q;
    ptr_d       = ptr_q;
    price_d     = price_q;
    mag_d       = mag_q;
    up_d        = up_q;
    sum_d       = sum_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    mul_cnt_d   = mul_cnt_q;
    mem_we      = 1'b0;
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;

    case (state_q)
      ST_IDLE: begin
        if (rsi_period_we_i) begin
          // new period drops the series
          period_d    = eff_period;
          have_prev_d = 1'b0;
          prev_d      = '0;
          gain_d      = '0;
          loss_d      = '0;
          seen_d      = '0;
          ptr_d       = '0;
        end else if (in_accept) begin
          price_d = price_i;
          if (series_start_i || !have_prev_q) begin
            have_prev_d = 1'b1;
            prev_d      = price_i;
            gain_d      = '0;
            loss_d      = '0;
            seen_d      = '0;
            ptr_d       = '0;
          end else begin
            state_d = ST_DELTA;
          end
        end
      end
      ST_DELTA: begin
        alu_op = ALU_SUB;
        alu_a  = NUM_W'(price_q);
        alu_b  = NUM_W'(prev_q);
        if (alu_carry) begin
          mag_d   = alu_res[PRICE_WIDTH-1:0];
          up_d    = 1'b1;
          state_d = ST_RETIRE;
        end else begin
          state_d = ST_NEG;
        end
      end
      ST_NEG: begin
        alu_op  = ALU_SUB;
        alu_a   = NUM_W'(prev_q);
        alu_b   = NUM_W'(price_q);
        mag_d   = alu_res[PRICE_WIDTH-1:0];
        up_d    = 1'b0;
        state_d = ST_RETIRE;
      end
      ST_RETIRE: begin
        // window full: drop the oldest change from its total
        if (seen_q >= period_q) begin
          alu_op = ALU_SUB;
          alu_a  = NUM_W'(old_up ? gain_q : loss_q);
          alu_b  = NUM_W'(old_mag);
          if (old_up) begin
            gain_d = alu_res[TOT_W-1:0];
          end else begin
            loss_d = alu_res[TOT_W-1:0];
          end
        end else begin
          seen_d = seen_q + CNT_W'(1);
        end
        state_d = ST_INSERT;
      end
      ST_INSERT: begin
        alu_op = ALU_ADD;
        alu_a  = NUM_W'(up_q ? gain_q : loss_q);
        alu_b  = NUM_W'(mag_q);
        if (up_q) begin
          gain_d = alu_res[TOT_W-1:0];
        end else begin
          loss_d = alu_res[TOT_W-1:0];
        end
        mem_we = 1'b1;
        ptr_d  = ptr_nxt;
        prev_d = price_q;
        state_d = (seen_q == period_q) ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (loss_q == '0) begin
          quo_d   = RSI_FULL_SCALE;
          state_d = ST_OUT;
        end else begin
          alu_op    = ALU_ADD;
          alu_a     = NUM_W'(gain_q);
          alu_b     = NUM_W'(loss_q);
          sum_d     = alu_res[TOT_W-1:0];
          num_d     = NUM_W'(gain_q) << scale_shift(SCALE_IDX_W'(0));
          mul_cnt_d = SCALE_IDX_W'(1);
          state_d   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        alu_op = ALU_ADD;
        alu_a  = num_q;
        alu_b  = NUM_W'(gain_q) << scale_shift(mul_cnt_q);
        num_d  = alu_res;
        if (mul_cnt_q == SCALE_IDX_W'(SCALE_TERMS - 1)) begin
          state_d = ST_DINIT;
        end else begin
          mul_cnt_d = mul_cnt_q + SCALE_IDX_W'(1);
        end
      end
      ST_DINIT: begin
        // quotient fits in RSI_W bits, so the high part is below the divisor
        rem_d   = num_q[NUM_W-1:RSI_W];
        quo_d   = '0;
        bit_d   = BIT_W'(RSI_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = NUM_W'(trial);
        alu_b  = NUM_W'(sum_q);
        if (alu_carry) begin
          rem_d = alu_res[TOT_W-1:0];
          quo_d = {quo_q[RSI_W-2:0], 1'b1};
        end else begin
          rem_d = trial[TOT_W-1:0];
          quo_d = {quo_q[RSI_W-2:0], 1'b0};
        end
        if (bit_q == '0) begin
          state_d = ST_OUT;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    rsi_d       = rsi_q;
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      rsi_d       = quo_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= ResetPeriod;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      gain_q      <= '0;
      loss_q      <= '0;
      seen_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      period_q    <= period_d;
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      gain_q      <= gain_d;
      loss_q      <= loss_d;
      seen_q      <= seen_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q   <= price_d;
    mag_q     <= mag_d;
    up_q      <= up_d;
    sum_q     <= sum_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    bit_q     <= bit_d;
    mul_cnt_q <= mul_cnt_d;
    rsi_q     <= rsi_d;
  end

  // change ring: read the oldest entry on accept, overwrite it on insert
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[ptr_q] <= {up_q, mag_q};
    end
    if (mem_re) begin
      mem_rd_q <= ring_mem[ptr_q];
    end
  end

endmodule

`default_nettype wire

/* design/rsi_checker.sv */
// Port-level checks for the relative strength index block, bound to the top level.
`default_nettype none

module rsi_checker import rsi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             series_start_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [RSI_W-1:0] rsi_value_o
);

  // an RSI never exceeds full scale
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rsi_value_o <= RSI_FULL_SCALE))
    else $error("rsi value above full scale");

  // a stalled result beat stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(rsi_value_o)))
    else $error("stalled result beat changed");

  // a fresh result only comes out of a busy period
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // a series start finishes in its accept cycle
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && series_start_i) |=> !in_stall_o)
    else $error("series start left the block busy");

endmodule

bind relative_strength_index rsi_checker u_rsi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .series_start_i (series_start_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .rsi_value_o    (rsi_value_o)
);

`default_nettype wire

/* verif/relative_strength_index_tb.sv */
// Self-checking testbench for the relative strength index block.
`timescale 1ns / 100ps

class rsi_tracker;
  int unsigned      period_reg;
  bit [31:0]        last_price;
  bit               have_last;
  bit [31:0]        gain_ring [64];
  bit [31:0]        loss_ring [64];
  bit [63:0]        up_total;
  bit [63:0]        down_total;
  int unsigned      filled;
  int unsigned      slot;
  bit [13:0]        expected_rsi [$];
  int unsigned      mismatches;
  int unsigned      beats;
  int unsigned      results_checked;

  function new();
    period_reg = rsi_pkg::PERIOD_RESET;
    mismatches = 0;
    beats = 0;
    results_checked = 0;
    clear_series();
  endfunction

  function void clear_series();
    up_total = '0;
    down_total = '0;
    filled = 0;
    slot = 0;
    have_last = 1'b0;
    last_price = '0;
  endfunction

  function void load_period(bit [6:0] value);
    period_reg = value;
    clear_series();
  endfunction

  function int unsigned pending();
    return expected_rsi.size();
  endfunction

  // Advance the window by one price beat and queue the RSI it yields.
  function void note_price(bit [31:0] price, bit start);
    int unsigned p;
    bit [31:0]   up;
    bit [31:0]   down;
    p = (period_reg == 0) ? 1 : (period_reg > 64) ? 64 : period_reg;
    beats++;
    if (start || !have_last) begin
      clear_series();
      last_price = price;
      have_last = 1'b1;
      return;
    end
    if (price > last_price) begin
      up = price - last_price;
      down = '0;
    end else begin
      up = '0;
      down = last_price - price;
    end
    last_price = price;
    if (slot >= p) slot = 0;
    if (filled >= p) begin
      up_total -= gain_ring[slot];
      down_total -= loss_ring[slot];
    end else begin
      filled++;
    end
    gain_ring[slot] = up;
    loss_ring[slot] = down;
    up_total += up;
    down_total += down;
    slot = (slot + 1 >= p) ? 0 : slot + 1;
    if (filled < p) return;
    if (down_total == 0) expected_rsi.push_back(rsi_pkg::RSI_FULL_SCALE);
    else expected_rsi.push_back(14'((up_total * 10000) / (up_total + down_total)));
  endfunction

  function void check_rsi(bit [13:0] actual);
    bit [13:0] want;
    if (expected_rsi.size() == 0) begin
      $error("rsi_value: expected none, actual %0d", actual);
      mismatches++;
      return;
    end
    want = expected_rsi.pop_front();
    results_checked++;
    if (actual !== want) begin
      $error("rsi_value: expected %0d, actual %0d", want, actual);
      mismatches++;
    end
  endfunction
endclass

module relative_strength_index_tb;
  import rsi_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int      SETTLE_CYCLES = 40;
  localparam int      PHASE_BEATS   = 165;
  localparam longint  TIMEOUT_NS    = 10_000_000;
  localparam int      NUM_PHASES    = 9;
  localparam int      PHASE_PERIOD [NUM_PHASES] = '{2, 64, 127, 0, 1, 3, 14, 33, -1};

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [PRICE_WIDTH_DEF-1:0] price_i = '0;
  logic                       series_start_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [RSI_W-1:0]           rsi_value_o;
  logic                       rsi_period_we_i = 1'b0;
  logic [PERIOD_W-1:0]        rsi_period_i = '0;

  rsi_tracker  tracker;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned period_writes = 0;

  relative_strength_index i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .price_i         (price_i),
    .series_start_i  (series_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rsi_value_o     (rsi_value_o),
    .rsi_period_we_i (rsi_period_we_i),
    .rsi_period_i    (rsi_period_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS * 1ns);
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Sample handshakes at the edge, before anything driven there settles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsi_period_we_i) tracker.load_period(rsi_period_i);
      if (in_valid_i && !in_stall_o) tracker.note_price(price_i, series_start_i);
      if (out_valid_o && !out_stall_i) tracker.check_rsi(rsi_value_o);
    end
  end

  task automatic set_idle(idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 55 : (mode == IDLE_BOTH) ? 30 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 55 : (mode == IDLE_BOTH) ? 30 : 0;
  endtask

  task automatic send_beat(bit [31:0] price, bit start);
    while ((send_idle_pct != 0) && ($urandom_range(0, 99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    price_i        <= price;
    series_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold input until every queued RSI is out, then let the block settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_period(bit [6:0] value);
    drain_results();
    rsi_period_we_i <= 1'b1;
    rsi_period_i    <= value;
    @(posedge clk_i);
    rsi_period_we_i <= 1'b0;
    period_writes++;
  endtask

  // Price walks with a per-series trend; rare restarts, jumps and rail values.
  task automatic run_random(int unsigned count);
    bit [31:0] level;
    bit [31:0] step;
    int unsigned trend;
    bit start;
    level = $urandom;
    trend = $urandom_range(0, 3);
    for (int unsigned i = 0; i < count; i++) begin
      start = ($urandom_range(0, 99) < 3);
      if (start) begin
        level = $urandom;
        trend = $urandom_range(0, 3);
      end
      case ($urandom_range(0, 99)) inside
        [0:4]:   level = $urandom;
        [5:7]:   level = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default: begin
          step = $urandom >> $urandom_range(4, 31);
          case (trend)
            1:       level = level + step;
            2:       level = level - step;
            3:       if ($urandom_range(0, 9) == 0) level = level + step;
            default: level = $urandom_range(0, 1) ? level + step : level - step;
          endcase
        end
      endcase
      send_beat(level, start);
      if (i == count / 2) drain_results();
    end
  endtask

  initial begin
    tracker = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idle(IDLE_NONE);

    // Reset period: first price without a start flag opens the series.
    for (int i = 0; i < 15; i++) send_beat(32'(100 + i), 1'b0);

    write_period(7'd1);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h0, 1'b0);
    send_beat(32'h0, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'd5, 1'b1);
    send_beat(32'd7, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_period((PHASE_PERIOD[ph] < 0) ? 7'($urandom_range(0, 127)) : 7'(PHASE_PERIOD[ph]));
      set_idle(idle_mode_e'(ph % 4));
      run_random(PHASE_BEATS);
    end

    set_idle(IDLE_NONE);
    drain_results();

    $display("Run covered %0d price beats and %0d RSI values over %0d period settings.",
             tracker.beats, tracker.results_checked, period_writes + 1);
    $display("Mismatches: %0d", tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
